// ===== src/rtmpdf_pkg.sv =====
// types, constants and a helper function shared by the rtmp chunk deframer
`timescale 1ns / 1ps
package rtmpdf_pkg;

    typedef enum logic [2:0] {
        PH_BASIC,
        PH_BASIC_MORE,
        PH_RESOLVE,
        PH_MSG,
        PH_EXT,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    localparam logic [1:0] FMT_FULL    = 2'd0;
    localparam logic [1:0] FMT_NO_SID  = 2'd1;
    localparam logic [1:0] FMT_TS_ONLY = 2'd2;
    localparam logic [1:0] FMT_NONE    = 2'd3;

    localparam logic [1:0] ERR_FRESH_NOT_FULL = 2'd0;
    localparam logic [1:0] ERR_FULL_MID_MSG   = 2'd1;
    localparam logic [1:0] ERR_LEN_CHANGED    = 2'd2;
    localparam logic [1:0] ERR_ID_TOO_LARGE   = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_ERROR   = 1'b1;

    // code 0 takes two more id bytes, code 1 takes one
    localparam logic [5:0]  BASIC_THREE_BYTE = 6'd0;
    localparam logic [5:0]  BASIC_TWO_BYTE   = 6'd1;
    localparam logic [16:0] CS_PROTOCOL      = 17'd2;
    localparam logic [16:0] CS_TWO_BYTE      = 17'd1;
    localparam logic [16:0] CS_ID_BASE       = 17'd64;

    localparam logic [16:0] MAX_CHUNK_RESET  = 17'd128;
    localparam logic [16:0] MAX_CHUNK_LIMIT  = 17'd65536;
    localparam logic [23:0] TS_EXTENDED      = 24'hffffff;

    // per chunk stream entry, 146 bits
    typedef struct packed {
        logic        started;
        logic        in_msg;
        logic        ext;
        logic [7:0]  msg_type;
        logic [30:0] time_stamp;
        logic [23:0] delta;
        logic [23:0] length;
        logic [31:0] sid;
        logic [23:0] received;
    } entry_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [16:0] chunk_stream;
        logic [7:0]  msg_type;
        logic [23:0] msg_length;
        logic [30:0] message_time;
        logic [31:0] message_stream_id;
        logic        first_of_message;
        logic        end_of_message;
        logic [1:0]  fault_code;
    } result_t;

    typedef struct packed {
        entry_t      ent;
        logic        to_payload;
        logic [16:0] bytes_left;
    } fin_t;

    // end of header: mark started, size the first payload run of this chunk
    function automatic fin_t finish_hdr(entry_t e, logic [16:0] csz);
        fin_t        f;
        logic [16:0] cs;
        logic [23:0] rest;
        f.ent = e;
        f.ent.started = 1'b1;
        f.to_payload = 1'b0;
        f.bytes_left = 17'd0;
        cs = csz;
        if (cs == 17'd0) cs = 17'd1;
        if (cs > MAX_CHUNK_LIMIT) cs = MAX_CHUNK_LIMIT;
        rest = (e.received < e.length) ? e.length - e.received : 24'd0;
        if (rest < {7'd0, cs})
            f.bytes_left = rest[16:0];
        else
            f.bytes_left = cs;
        if (e.length == 24'd0 || f.bytes_left == 17'd0)
        begin
            f.ent.in_msg = 1'b0;
            f.ent.received = 24'd0;
        end
        else
        begin
            f.to_payload = 1'b1;
        end
        return f;
    endfunction

endpackage

// ===== src/rtmpdf_ifs.sv =====
// valid/ready channel interfaces of the rtmp chunk deframer
`timescale 1ns / 1ps
interface rtmpdf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface rtmpdf_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] max_chunk;
    modport source (output valid, output max_chunk, input ready);
    modport sink (input valid, input max_chunk, output ready);
endinterface

interface rtmpdf_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [16:0] chunk_stream;
    logic [7:0]  msg_type;
    logic [23:0] msg_length;
    logic [30:0] message_time;
    logic [31:0] message_stream_id;
    logic        first_of_message;
    logic        end_of_message;
    logic [1:0]  fault_code;
    modport source (output valid, output kind, output payload_byte, output chunk_stream,
                    output msg_type, output msg_length, output message_time,
                    output message_stream_id, output first_of_message,
                    output end_of_message, output fault_code, input ready);
    modport sink (input valid, input kind, input payload_byte, input chunk_stream,
                  input msg_type, input msg_length, input message_time,
                  input message_stream_id, input first_of_message,
                  input end_of_message, input fault_code, output ready);
endinterface

// ===== src/rtmpdf_table.sv =====
// per chunk stream table: registered-read memory with a clearing sweep after reset
`timescale 1ns / 1ps
module rtmpdf_table #(
    parameter int STREAM_SLOTS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            rd_en,
    input  logic [$clog2(STREAM_SLOTS)-1:0] rd_idx,
    output rtmpdf_pkg::entry_t              rd_data,
    input  logic                            wr_en,
    input  logic [$clog2(STREAM_SLOTS)-1:0] wr_idx,
    input  rtmpdf_pkg::entry_t              wr_data,
    output logic                            busy
);
    localparam int SW = $clog2(STREAM_SLOTS);

    rtmpdf_pkg::entry_t mem [STREAM_SLOTS];
    rtmpdf_pkg::entry_t rd_data_reg;
    logic               clr_busy_reg;
    logic [SW-1:0]      clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == SW'(STREAM_SLOTS - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_idx_reg] <= '0;
        else if (wr_en)
            mem[wr_idx] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_idx];
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;
endmodule

// ===== src/rtmp_chunk_deframer.sv =====
// rtmp chunk deframer top level: header parser, stream table access, output register
//
//  channel   dir  carries                              accepted when
//  in_ch     in   data_byte, one received byte         valid && ready
//  cfg_ch    in   max_chunk register write             valid && ready (ready always high)
//  out_ch    out  payload byte with header fields,     valid && ready
//                 or one protocol error
//
// one byte per cycle while the output register is free; after the last basic header
// byte of each chunk, input waits in the resolve state on the stream table read
// after reset the stream table is swept clear, all STREAM_SLOTS entries, with ready low
// a single output register sits between the sides; a byte is taken while a result
// waits as long as that result is taken in the same cycle
// after a protocol error every byte is taken and dropped until reset
`timescale 1ns / 1ps
module rtmp_chunk_deframer #(
    parameter int STREAM_SLOTS = 64
) (
    input  logic   clk,
    input  logic   rst_n,
    rtmpdf_in_if.sink    in_ch,
    rtmpdf_cfg_if.sink   cfg_ch,
    rtmpdf_out_if.source out_ch
);
    localparam int SW = $clog2(STREAM_SLOTS);

    // parser state
    rtmpdf_pkg::phase_t  phase_reg, phase_next;
    logic [3:0]          fbc_reg, fbc_next;
    logic [16:0]         cur_stream_reg, cur_stream_next;
    logic [1:0]          fmt_reg, fmt_next;
    logic [55:0]         hs_reg, hs_next;
    logic [16:0]         cbl_reg, cbl_next;
    logic                first_reg, first_next;
    rtmpdf_pkg::entry_t  ent_reg, ent_next;
    logic [16:0]         max_chunk_reg;

    // output register
    logic                out_valid_reg, out_valid_next;
    rtmpdf_pkg::result_t out_reg, out_next;

    // table port
    logic                tbl_rd_en, tbl_wr_en, tbl_busy;
    rtmpdf_pkg::entry_t  tbl_rd_data;

    logic                out_free, acc, resolve_go;

    // handshake
    always_comb
    begin
        out_free   = !out_valid_reg || out_ch.ready;
        in_ch.ready = !tbl_busy && (phase_reg != rtmpdf_pkg::PH_RESOLVE) && out_free;
        acc        = in_ch.valid && in_ch.ready;
        resolve_go = (phase_reg == rtmpdf_pkg::PH_RESOLVE) && out_free;
    end

    assign cfg_ch.ready = 1'b1;

    // next state
    always_comb
    begin
        logic [7:0]          b;
        logic                basic_fire;
        logic [16:0]         cid;
        logic                res_valid;
        rtmpdf_pkg::result_t res;
        rtmpdf_pkg::entry_t  e;
        rtmpdf_pkg::fin_t    f;
        logic                hdr_end;
        logic [3:0]          n;
        logic [55:0]         hs_new;
        logic [23:0]         len;
        logic [30:0]         ts;
        logic [23:0]         rcv;

        b = in_ch.data_byte;
        basic_fire = 1'b0;
        cid = '0;
        res_valid = 1'b0;
        res = '0;
        e = ent_reg;
        f = '0;
        hdr_end = 1'b0;
        n = fbc_reg + 4'd1;
        hs_new = hs_reg;
        len = '0;
        ts = '0;
        rcv = '0;

        phase_next = phase_reg;
        fbc_next = fbc_reg;
        cur_stream_next = cur_stream_reg;
        fmt_next = fmt_reg;
        hs_next = hs_reg;
        cbl_next = cbl_reg;
        first_next = first_reg;
        ent_next = ent_reg;
        tbl_rd_en = 1'b0;
        tbl_wr_en = 1'b0;

        unique case (phase_reg)
            rtmpdf_pkg::PH_BASIC:
            begin
                if (acc)
                begin
                    fmt_next = b[7:6];
                    if (b[5:0] != rtmpdf_pkg::BASIC_TWO_BYTE &&
                        b[5:0] != rtmpdf_pkg::BASIC_THREE_BYTE)
                    begin
                        basic_fire = 1'b1;
                        cid = {11'd0, b[5:0]};
                    end
                    else
                    begin
                        cur_stream_next = {11'd0, b[5:0]};
                        fbc_next = 4'd0;
                        hs_next = '0;
                        phase_next = rtmpdf_pkg::PH_BASIC_MORE;
                    end
                end
            end
            rtmpdf_pkg::PH_BASIC_MORE:
            begin
                if (acc)
                begin
                    if (cur_stream_reg == rtmpdf_pkg::CS_TWO_BYTE)
                    begin
                        basic_fire = 1'b1;
                        cid = rtmpdf_pkg::CS_ID_BASE + {9'd0, b};
                    end
                    else if (fbc_reg == 4'd0)
                    begin
                        hs_next = {48'd0, b};
                        fbc_next = 4'd1;
                    end
                    else
                    begin
                        basic_fire = 1'b1;
                        cid = rtmpdf_pkg::CS_ID_BASE + {9'd0, hs_reg[7:0]}
                              + {1'b0, b, 8'd0};
                    end
                end
            end
            rtmpdf_pkg::PH_RESOLVE:
            begin
                if (resolve_go)
                begin
                    e = tbl_rd_data;
                    if (!e.started && fmt_reg != rtmpdf_pkg::FMT_FULL &&
                        !(cur_stream_reg == rtmpdf_pkg::CS_PROTOCOL &&
                          fmt_reg == rtmpdf_pkg::FMT_NO_SID))
                    begin
                        res_valid = 1'b1;
                        res.kind = rtmpdf_pkg::KIND_ERROR;
                        res.chunk_stream = cur_stream_reg;
                        res.fault_code = rtmpdf_pkg::ERR_FRESH_NOT_FULL;
                        phase_next = rtmpdf_pkg::PH_HALT;
                    end
                    else if (e.in_msg && fmt_reg == rtmpdf_pkg::FMT_FULL)
                    begin
                        res_valid = 1'b1;
                        res.kind = rtmpdf_pkg::KIND_ERROR;
                        res.chunk_stream = cur_stream_reg;
                        res.fault_code = rtmpdf_pkg::ERR_FULL_MID_MSG;
                        phase_next = rtmpdf_pkg::PH_HALT;
                    end
                    else
                    begin
                        first_next = !e.in_msg;
                        if (fmt_reg == rtmpdf_pkg::FMT_NONE)
                        begin
                            // continuation of a new message reuses the last delta
                            if (!e.in_msg && !e.ext)
                                e.time_stamp = e.time_stamp + 31'(e.delta);
                            hdr_end = 1'b1;
                        end
                        else
                        begin
                            phase_next = rtmpdf_pkg::PH_MSG;
                            fbc_next = 4'd0;
                            hs_next = '0;
                        end
                        e.in_msg = 1'b1;
                        tbl_wr_en = 1'b1;
                    end
                end
            end
            rtmpdf_pkg::PH_MSG:
            begin
                if (acc)
                begin
                    if (fbc_reg >= 4'd7)
                        hs_new = hs_reg | ({48'd0, b} << {fbc_reg[1:0] - 2'd3, 3'd0});
                    else
                        hs_new = {hs_reg[47:0], b};
                    hs_next = hs_new;
                    fbc_next = n;
                    tbl_wr_en = 1'b1;
                    if (n == 4'd3)
                    begin
                        e.delta = hs_new[23:0];
                        e.ext = (hs_new[23:0] == rtmpdf_pkg::TS_EXTENDED);
                        if (!e.ext)
                        begin
                            if (fmt_reg == rtmpdf_pkg::FMT_FULL)
                                e.time_stamp = {7'd0, hs_new[23:0]};
                            else
                                e.time_stamp = e.time_stamp + 31'(hs_new[23:0]);
                        end
                        if (fmt_reg == rtmpdf_pkg::FMT_TS_ONLY)
                            hdr_end = 1'b1;
                    end
                    else if (n == 4'd7)
                    begin
                        len = hs_new[31:8];
                        if (!first_reg && e.length != len)
                        begin
                            res_valid = 1'b1;
                            res.kind = rtmpdf_pkg::KIND_ERROR;
                            res.chunk_stream = cur_stream_reg;
                            res.fault_code = rtmpdf_pkg::ERR_LEN_CHANGED;
                            phase_next = rtmpdf_pkg::PH_HALT;
                            tbl_wr_en = 1'b0;
                        end
                        else
                        begin
                            e.length = len;
                            e.msg_type = hs_new[7:0];
                            hs_next = '0;
                            if (fmt_reg == rtmpdf_pkg::FMT_NO_SID)
                                hdr_end = 1'b1;
                        end
                    end
                    else if (n >= 4'd11)
                    begin
                        e.sid = hs_new[31:0];
                        hdr_end = 1'b1;
                    end
                end
            end
            rtmpdf_pkg::PH_EXT:
            begin
                if (acc)
                begin
                    hs_new = {24'd0, hs_reg[23:0], b};
                    hs_next = hs_new;
                    fbc_next = n;
                    if (n >= 4'd4)
                    begin
                        ts = hs_new[30:0];
                        // a mismatched stamp on a continued chunk keeps a nonzero stored one
                        if (!(!first_reg && e.time_stamp != 31'd0 && e.time_stamp != ts))
                            e.time_stamp = ts;
                        f = rtmpdf_pkg::finish_hdr(e, max_chunk_reg);
                        e = f.ent;
                        cbl_next = f.bytes_left;
                        phase_next = f.to_payload ? rtmpdf_pkg::PH_PAYLOAD
                                                  : rtmpdf_pkg::PH_BASIC;
                        tbl_wr_en = 1'b1;
                    end
                end
            end
            rtmpdf_pkg::PH_PAYLOAD:
            begin
                if (acc)
                begin
                    res_valid = 1'b1;
                    res.kind = rtmpdf_pkg::KIND_PAYLOAD;
                    res.payload_byte = b;
                    res.chunk_stream = cur_stream_reg;
                    res.msg_type = e.msg_type;
                    res.msg_length = e.length;
                    res.message_time = e.time_stamp;
                    res.message_stream_id = e.sid;
                    res.first_of_message = (e.received == 24'd0);
                    res.end_of_message = ({1'b0, e.received} + 25'd1 == {1'b0, e.length});
                    rcv = e.received + 24'd1;
                    e.received = rcv;
                    if (cbl_reg != 17'd0)
                        cbl_next = cbl_reg - 17'd1;
                    if (rcv >= e.length)
                    begin
                        e.in_msg = 1'b0;
                        e.received = 24'd0;
                        phase_next = rtmpdf_pkg::PH_BASIC;
                    end
                    else if (cbl_reg <= 17'd1)
                    begin
                        phase_next = rtmpdf_pkg::PH_BASIC;
                    end
                    tbl_wr_en = 1'b1;
                end
            end
            rtmpdf_pkg::PH_HALT:
            begin
                phase_next = rtmpdf_pkg::PH_HALT;
            end
            default:
            begin
                phase_next = rtmpdf_pkg::PH_HALT;
            end
        endcase

        // header end: extended stamp follows, or payload sizing
        if (hdr_end)
        begin
            if (e.ext)
            begin
                phase_next = rtmpdf_pkg::PH_EXT;
                fbc_next = 4'd0;
                hs_next = '0;
            end
            else
            begin
                f = rtmpdf_pkg::finish_hdr(e, max_chunk_reg);
                e = f.ent;
                cbl_next = f.bytes_left;
                phase_next = f.to_payload ? rtmpdf_pkg::PH_PAYLOAD : rtmpdf_pkg::PH_BASIC;
            end
        end

        // stream id known: range check now, table read for the rest
        if (basic_fire)
        begin
            cur_stream_next = cid;
            if (cid >= 17'(STREAM_SLOTS))
            begin
                res_valid = 1'b1;
                res.kind = rtmpdf_pkg::KIND_ERROR;
                res.chunk_stream = cid;
                res.fault_code = rtmpdf_pkg::ERR_ID_TOO_LARGE;
                phase_next = rtmpdf_pkg::PH_HALT;
            end
            else
            begin
                tbl_rd_en = 1'b1;
                phase_next = rtmpdf_pkg::PH_RESOLVE;
            end
        end

        ent_next = e;
        out_next = res_valid ? res : out_reg;
        if (res_valid)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= rtmpdf_pkg::PH_BASIC;
            fbc_reg        <= '0;
            cur_stream_reg <= '0;
            fmt_reg        <= '0;
            hs_reg         <= '0;
            cbl_reg        <= '0;
            first_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            max_chunk_reg  <= rtmpdf_pkg::MAX_CHUNK_RESET;
        end
        else
        begin
            phase_reg      <= phase_next;
            fbc_reg        <= fbc_next;
            cur_stream_reg <= cur_stream_next;
            fmt_reg        <= fmt_next;
            hs_reg         <= hs_next;
            cbl_reg        <= cbl_next;
            first_reg      <= first_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_ch.valid)
                max_chunk_reg <= cfg_ch.max_chunk;
        end
    end

    // working copy of the current stream's entry and the result payload
    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        out_reg <= out_next;
    end

    rtmpdf_table #(
        .STREAM_SLOTS (STREAM_SLOTS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (tbl_rd_en),
        .rd_idx  (cur_stream_next[SW-1:0]),
        .rd_data (tbl_rd_data),
        .wr_en   (tbl_wr_en),
        .wr_idx  (cur_stream_reg[SW-1:0]),
        .wr_data (ent_next),
        .busy    (tbl_busy)
    );

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.kind              = out_reg.kind;
    assign out_ch.payload_byte      = out_reg.payload_byte;
    assign out_ch.chunk_stream      = out_reg.chunk_stream;
    assign out_ch.msg_type          = out_reg.msg_type;
    assign out_ch.msg_length        = out_reg.msg_length;
    assign out_ch.message_time      = out_reg.message_time;
    assign out_ch.message_stream_id = out_reg.message_stream_id;
    assign out_ch.first_of_message  = out_reg.first_of_message;
    assign out_ch.end_of_message    = out_reg.end_of_message;
    assign out_ch.fault_code        = out_reg.fault_code;
endmodule
